// ===== rtl/core/lgs_pkg.sv =====
// ----------------------------------------------------------------------------
// lgs_pkg: shared codes for the life grid generation step
// Request codes, field widths and the B3/S23 rule counts.
// ----------------------------------------------------------------------------
package lgs_pkg;

	localparam int unsigned REQ_W   = 2;
	localparam int unsigned INDEX_W = 4;
	localparam int unsigned FIELD_W = 16;
	localparam int unsigned COUNT_W = 4;

	typedef logic [REQ_W-1:0]   req_code_t;
	typedef logic [COUNT_W-1:0] nbr_count_t;

	localparam req_code_t REQ_LOAD    = 2'd0;
	localparam req_code_t REQ_ADVANCE = 2'd1;
	localparam req_code_t REQ_READ    = 2'd2;

	localparam nbr_count_t BIRTH_COUNT  = 4'd3;
	localparam nbr_count_t SURVIVE_LOW  = 4'd2;
	localparam nbr_count_t SURVIVE_HIGH = 4'd3;

endpackage

// ===== rtl/core/life_grid_generation_step.sv =====
// ----------------------------------------------------------------------------
// life_grid_generation_step: bounded Game of Life grid, rule B3/S23
// Holds a GRID_ROWS x GRID_COLS grid of one-bit cells in a row memory. Takes
// load-row, advance-generation and read-row requests, one response word each.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  request | in        | req_valid/req_stall  | req_type, row_index, row_cells
//  response| out       | rsp_valid/rsp_stall  | row_data
//
//  A load or unused code is answered at accept; a read goes through ST_RD
//  (the row memory read is registered); an advance loads row 0 into the
//  window in ST_FILL, then takes each row through the shared next-row unit.
//  Reset clears all row valid bits at once; a row never written reads dead.
//  req_stall is high while a request is in progress and while a response word
//  waits under rsp_stall; a stalled response holds its word.
//
module life_grid_generation_step
	import lgs_pkg::*;
#(
	parameter int GRID_ROWS = 16,
	parameter int GRID_COLS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [REQ_W-1:0]   req_type,
	input  logic [INDEX_W-1:0] row_index,
	input  logic [FIELD_W-1:0] row_cells,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [FIELD_W-1:0] row_data
);

	localparam int AW = $clog2(GRID_ROWS);
	localparam int IW = (AW > INDEX_W) ? AW + 1 : INDEX_W + 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_FILL = 2'd2;
	localparam logic [1:0] ST_WALK = 2'd3;

	// Row memory and per-row valid bits (a row never written reads dead)
	logic [GRID_COLS-1:0] grid_mem [GRID_ROWS];
	logic [GRID_ROWS-1:0] row_vld_q;
	logic [GRID_COLS-1:0] rd_data_q;
	logic                 rd_vld_q;

	logic [1:0]           state_q;
	logic [AW-1:0]        cnt_q;
	logic [GRID_COLS-1:0] above_q;
	logic [GRID_COLS-1:0] cur_q;
	logic                 rd_ok_q;
	logic                 rsp_valid_q;
	logic [FIELD_W-1:0]   row_data_q;

	logic                 req_acc;
	logic                 rsp_acc;
	logic                 rsp_set;
	logic                 idx_in_range;
	logic [AW-1:0]        idx_addr;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [GRID_COLS-1:0] wr_data;
	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic [AW:0]          next_rd;
	logic                 last_row;
	logic [GRID_COLS-1:0] rd_row;
	logic [GRID_COLS-1:0] below_w;
	logic [GRID_COLS-1:0] new_row;

	assign req_acc      = req_valid && !req_stall;
	assign rsp_acc      = rsp_valid_q && !rsp_stall;
	assign req_stall    = (state_q != ST_IDLE) || (rsp_valid_q && rsp_stall);
	assign idx_in_range = IW'(row_index) < IW'(GRID_ROWS);
	assign idx_addr     = AW'(row_index);
	assign last_row     = cnt_q == AW'(GRID_ROWS - 1);
	assign next_rd      = {1'b0, cnt_q} + (AW + 1)'(2);
	assign rd_row       = rd_vld_q ? rd_data_q : '0;
	assign below_w      = last_row ? '0 : rd_row;

	// Raise the response word: load and unused codes at accept, a read after
	// its memory cycle, an advance after its last row
	assign rsp_set = (state_q == ST_IDLE && req_acc && req_type != REQ_READ
			&& req_type != REQ_ADVANCE)
		|| (state_q == ST_RD)
		|| (state_q == ST_WALK && last_row);

	// Shared next-row unit: all columns of one row per cycle
	always_comb begin
		logic [GRID_COLS-1:0] wa, ea, wc, ec, wb, eb;
		nbr_count_t n;
		wa = {above_q[GRID_COLS-2:0], 1'b0};
		ea = {1'b0, above_q[GRID_COLS-1:1]};
		wc = {cur_q[GRID_COLS-2:0], 1'b0};
		ec = {1'b0, cur_q[GRID_COLS-1:1]};
		wb = {below_w[GRID_COLS-2:0], 1'b0};
		eb = {1'b0, below_w[GRID_COLS-1:1]};
		new_row = '0;
		for (int c = 0; c < GRID_COLS; c++) begin
			n = COUNT_W'(wa[c]) + COUNT_W'(above_q[c]) + COUNT_W'(ea[c])
			  + COUNT_W'(wc[c]) + COUNT_W'(ec[c])
			  + COUNT_W'(wb[c]) + COUNT_W'(below_w[c]) + COUNT_W'(eb[c]);
			if (cur_q[c]) begin
				new_row[c] = (n == SURVIVE_LOW) || (n == SURVIVE_HIGH);
			end else begin
				new_row[c] = (n == BIRTH_COUNT);
			end
		end
	end

	// Memory port control
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_addr;
		wr_data = GRID_COLS'(row_cells);
		rd_en   = 1'b0;
		rd_addr = idx_addr;
		case (state_q)
			ST_IDLE: begin
				if (req_acc && req_type == REQ_LOAD && idx_in_range) begin
					wr_en = 1'b1;
				end
				if (req_acc && req_type == REQ_READ && idx_in_range) begin
					rd_en = 1'b1;
				end
				if (req_acc && req_type == REQ_ADVANCE) begin
					rd_en   = 1'b1;
					rd_addr = '0;
				end
			end
			ST_FILL: begin
				rd_en   = 1'b1;
				rd_addr = AW'(1);
			end
			ST_WALK: begin
				wr_en   = 1'b1;
				wr_addr = cnt_q;
				wr_data = new_row;
				rd_en   = next_rd < (AW + 1)'(GRID_ROWS);
				rd_addr = next_rd[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			grid_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= grid_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= row_vld_q[rd_addr];
			end
		end
	end

	// Sequencer and response word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_set) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_acc) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						if (req_type == REQ_READ) begin
							state_q <= ST_RD;
						end else if (req_type == REQ_ADVANCE) begin
							state_q <= ST_FILL;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_IDLE;
				end
				ST_FILL: begin
					cnt_q   <= '0;
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (last_row) begin
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: old-row window and response data
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rd_ok_q <= idx_in_range;
				if (req_acc) begin
					above_q    <= '0;
					row_data_q <= '0;
				end
			end
			ST_RD: begin
				row_data_q <= rd_ok_q ? FIELD_W'(rd_row) : '0;
			end
			ST_FILL: begin
				cur_q <= rd_row;
			end
			ST_WALK: begin
				// slide the window: current becomes above, below becomes current
				above_q    <= cur_q;
				cur_q      <= below_w;
				row_data_q <= '0;
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign row_data  = row_data_q;

endmodule
